// ===== design/tags_pkg.sv =====
package tags_pkg;

  // Field widths
  localparam int unsigned AdcW   = 13;
  localparam int unsigned CteW   = 10;
  localparam int unsigned KindW  = 2;
  localparam int unsigned TrigW  = 8;
  localparam int unsigned MagW   = 12;   // magnitude bits of a non-negative sample
  localparam int unsigned SumW   = 20;   // bits 19:0 of the partial-product sum
  localparam int unsigned NumPp  = 8;

  // Configuration port
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CfgAddrW = 3;

  // Register indexes (paddr[2])
  localparam logic REG_DOUBLE_SCALE  = 1'b0;
  localparam logic REG_FIX_YEAR_MODE = 1'b1;

  // Calorimeter kind that takes the forced constant
  localparam logic [KindW-1:0] KIND_FORCED = 2'd2;
  localparam logic [CteW-1:0]  CTE_FORCED  = 10'd127;

  // Front-end truncation masks, one per partial product
  localparam logic [SumW-1:0] PP_MASK [NumPp] = '{
    20'h00FFC, 20'h01FFC, 20'h03FF0, 20'h07FF0,
    20'h0FFC0, 20'h1FFC0, 20'h3FF00, 20'h7FF00
  };
  localparam logic [SumW-1:0] PAIR_MASK = 20'hFFF00;
  localparam logic [MagW-1:0] ADC_SAT   = 12'hFFF;
  localparam logic [TrigW-1:0] TRIG_MAX = 8'hFF;

  typedef struct packed {
    logic double_scale;
    logic fix_year_mode;
  } cfg_t;

endpackage

// ===== design/tags_if.sv =====
interface tags_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [tags_pkg::AdcW-1:0]    adc_sample;
  logic        [tags_pkg::CteW-1:0]    calib_constant;
  logic        [tags_pkg::KindW-1:0]   calo_kind;

  modport source (output valid, adc_sample, calib_constant, calo_kind, input ready);
  modport sink   (input valid, adc_sample, calib_constant, calo_kind, output ready);
endinterface

interface tags_out_if;
  logic                                valid;
  logic                                ready;
  logic [tags_pkg::TrigW-1:0]          trigger_adc;

  modport source (output valid, trigger_adc, input ready);
  modport sink   (input valid, trigger_adc, output ready);
endinterface

// ===== design/tags_scale.sv =====
module tags_scale (
  input  tags_pkg::cfg_t                    cfg,
  input  logic signed [tags_pkg::AdcW-1:0]  adc_sample,
  input  logic [tags_pkg::CteW-1:0]         calib_constant,
  input  logic [tags_pkg::KindW-1:0]        calo_kind,
  output logic [tags_pkg::TrigW-1:0]        trigger_adc
);

  logic [tags_pkg::CteW-1:0]   cte_half;
  logic [tags_pkg::CteW-1:0]   cte_sel;
  logic [tags_pkg::TrigW-1:0]  cte_eff;
  logic [tags_pkg::MagW-1:0]   mag;
  logic [tags_pkg::SumW-1:0]   pp [tags_pkg::NumPp];
  logic [tags_pkg::SumW-1:0]   pair [tags_pkg::NumPp/2];
  logic [tags_pkg::SumW-1:0]   sum;
  logic [tags_pkg::TrigW-1:0]  trig_base;
  logic                        round_up;

  // Effective constant: halve on double_scale, then force for the selected kind in fix_year_mode
  always_comb begin
    cte_half = cfg.double_scale ? {1'b0, calib_constant[tags_pkg::CteW-1:1]}
                                : calib_constant;
    cte_sel  = (cfg.fix_year_mode && calo_kind == tags_pkg::KIND_FORCED)
               ? tags_pkg::CTE_FORCED : cte_half;
  end

  // Large constant: quarter it and quadruple the sample, saturating
  always_comb begin
    if (cte_sel[9:8] != 2'b00) begin
      mag     = (adc_sample[11:10] != 2'b00) ? tags_pkg::ADC_SAT
                                             : {adc_sample[9:0], 2'b00};
      cte_eff = cte_sel[9:2];
    end else begin
      mag     = adc_sample[tags_pkg::MagW-1:0];
      cte_eff = cte_sel[7:0];
    end
  end

  // Masked shifted partial products, summed in truncated pairs
  always_comb begin
    for (int i = 0; i < tags_pkg::NumPp; i++) begin
      pp[i] = cte_eff[i] ? (({{(tags_pkg::SumW-tags_pkg::MagW){1'b0}}, mag} << i)
                            & tags_pkg::PP_MASK[i])
                         : '0;
    end
    for (int j = 0; j < tags_pkg::NumPp/2; j++) begin
      pair[j] = (pp[2*j] + pp[2*j+1]) & tags_pkg::PAIR_MASK;
    end
    sum = pair[0] + pair[1] + pair[2] + pair[3];
  end

  // Zero for a negative sample, else round by bit 9 below full scale, saturate on bits 19:18
  always_comb begin
    trig_base = sum[17:10];
    round_up  = sum[9] && (trig_base != tags_pkg::TRIG_MAX);
    if (adc_sample[tags_pkg::AdcW-1]) begin
      trigger_adc = '0;
    end else if (sum[19:18] != 2'b00) begin
      trigger_adc = tags_pkg::TRIG_MAX;
    end else begin
      trigger_adc = trig_base + {{(tags_pkg::TrigW-1){1'b0}}, round_up};
    end
  end

endmodule

// ===== design/trigger_adc_gain_scaler.sv =====
// Trigger ADC gain scaler: turns one signed calorimeter sample, its calibration
// constant and calorimeter kind into an 8-bit trigger ADC with the front-end's
// truncated shift-add multiply. Requests pass through two register stages: an
// input register and a result register, with the scaling logic between them.
// The input register captures an accepted request, and the result register
// takes its scaled result once it is free or draining. Throughput is one
// request per cycle while out ready is held high, set by that single scaling
// stage. in ready follows out ready combinationally when both stages are
// full. Registers double_scale (byte 0) and fix_year_mode (byte 4) are written
// over the configuration port; the user must write them only while the block
// is idle, which the block itself does not enforce; pready is always high.
module trigger_adc_gain_scaler (
  input  logic                               clk,
  input  logic                               rst_n,
  tags_in_if.sink                            in_chan,
  tags_out_if.source                         out_chan,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tags_pkg::CfgAddrW-1:0]      paddr,
  input  logic [tags_pkg::CfgDataW-1:0]      pwdata,
  output logic [tags_pkg::CfgDataW-1:0]      prdata,
  output logic                               pready
);

  tags_pkg::cfg_t                    cfg_r;
  logic                              v1_r;
  logic signed [tags_pkg::AdcW-1:0]  adc_r;
  logic [tags_pkg::CteW-1:0]         cte_r;
  logic [tags_pkg::KindW-1:0]        kind_r;
  logic                              out_valid_r;
  logic [tags_pkg::TrigW-1:0]        trig_r;
  logic [tags_pkg::TrigW-1:0]        trig_nxt;
  logic                              in_acc;
  logic                              adv;
  logic                              cfg_wr;

  // Handshake: stage 1 moves on when the result register is free or drains
  assign adv           = !out_valid_r || out_chan.ready;
  assign in_chan.ready = !v1_r || adv;
  assign in_acc        = in_chan.valid && in_chan.ready;

  assign out_chan.valid       = out_valid_r;
  assign out_chan.trigger_adc = trig_r;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        tags_pkg::REG_DOUBLE_SCALE:  cfg_r.double_scale  <= pwdata[0];
        tags_pkg::REG_FIX_YEAR_MODE: cfg_r.fix_year_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      tags_pkg::REG_DOUBLE_SCALE:  prdata[0] = cfg_r.double_scale;
      tags_pkg::REG_FIX_YEAR_MODE: prdata[0] = cfg_r.fix_year_mode;
      default: ;
    endcase
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_chan.ready) v1_r <= in_chan.valid;
      if (adv)           out_valid_r <= v1_r;
    end
  end

  // Hold the input request
  always_ff @(posedge clk) begin
    if (in_acc) begin
      adc_r  <= in_chan.adc_sample;
      cte_r  <= in_chan.calib_constant;
      kind_r <= in_chan.calo_kind;
    end
  end

  tags_scale u_scale (
    .cfg            (cfg_r),
    .adc_sample     (adc_r),
    .calib_constant (cte_r),
    .calo_kind      (kind_r),
    .trigger_adc    (trig_nxt)
  );

  // Capture the result
  always_ff @(posedge clk) begin
    if (adv && v1_r) begin
      trig_r <= trig_nxt;
    end
  end

  // Checks
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> v1_r)
    else $error("accepted request not held in input stage");

  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && !out_valid_r) |=> out_valid_r)
    else $error("input stage did not move into empty result register");

  a_neg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && adv && adc_r[tags_pkg::AdcW-1]) |=> (trig_r == '0))
    else $error("negative sample gave nonzero result");

  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr && paddr[2] == tags_pkg::REG_DOUBLE_SCALE)
      |=> (cfg_r.double_scale == $past(pwdata[0])))
    else $error("double_scale write lost");

endmodule
